[hw/rtl/tdpt_pkg.sv]
// Shared types and constants for the trial-division prime test.
`default_nettype none

package tdpt_pkg;

    localparam int CANDIDATE_WIDTH = 32;
    localparam int WHEEL_START     = 5;
    localparam int WHEEL_STEP      = 6;
    localparam int PAIR_OFFSET     = 2;
    localparam int SMALL_DIVISOR   = 3;
    localparam int LARGEST_TRIVIAL = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_DIV3,
        ST_DIVLO,
        ST_DIVHI,
        ST_RESULT
    } tdpt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tdpt_div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/trial_division_prime_test.sv]
// Top level: trial-division prime test over the 6k +/- 1 wheel.
//
// Input channel s_valid/s_ready carries one signed candidate per beat; the
// result channel m_valid/m_ready returns one beat with m_is_prime_flag.
// The low VALUE_WIDTH bits of the candidate are tested, sign at the top one.
// Negative values, 0 and 1, 2 and 3, and even values are answered from the
// screen state. Odd values run a divide by 3 and then one divider pass per
// divisor d = 5, 11, 17, ... and d+2 while d <= n/d. The single bit-serial
// divider is shared by all divide states; one item is worked on at a time.
// s_ready is high while no item is in work, also while a result beat waits
// for m_ready. A finished item waits in its final state until the output
// register is free. Synchronous active-low reset empties the block and drops
// any result not yet taken.
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_candidate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_prime_flag
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = tdpt_pkg::CANDIDATE_WIDTH;

    tdpt_pkg::tdpt_state_t state_reg, state_next;
    logic [W-1:0]          n_reg, n_next;
    logic [W-1:0]          d_reg, d_next;
    logic                  prime_reg, prime_next;
    logic                  m_valid_reg;
    logic                  m_flag_reg;

    logic [W-1:0]          cand_ext;
    logic                  div_start;
    logic [W-1:0]          div_divisor;
    logic [W-1:0]          div_quot;
    logic [W-1:0]          div_rem;
    tdpt_pkg::tdpt_div_stat_t div_stat;
    logic                  in_div;
    logic                  out_free;

    generate
        if (W > CW) begin : g_wide
            assign cand_ext = {{(W-CW){1'b0}}, s_candidate};
        end else begin : g_narrow
            assign cand_ext = s_candidate[W-1:0];
        end
    endgenerate

    tdpt_serial_div #(
        .VALUE_WIDTH (W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        prime_next = prime_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    n_next     = cand_ext;
                    state_next = tdpt_pkg::ST_SCREEN;
                end
            end
            tdpt_pkg::ST_SCREEN: begin
                d_next = W'(tdpt_pkg::WHEEL_START);
                if (n_reg[W-1] || n_reg <= W'(1)) begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_RESULT;
                end else if (n_reg <= W'(tdpt_pkg::LARGEST_TRIVIAL)) begin
                    prime_next = 1'b1;
                    state_next = tdpt_pkg::ST_RESULT;
                end else if (!n_reg[0]) begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_RESULT;
                end else begin
                    state_next = tdpt_pkg::ST_DIV3;
                end
            end
            tdpt_pkg::ST_DIV3: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_RESULT;
                    end else begin
                        state_next = tdpt_pkg::ST_DIVLO;
                    end
                end
            end
            tdpt_pkg::ST_DIVLO: begin
                if (div_stat.done) begin
                    if (d_reg > div_quot) begin
                        prime_next = 1'b1;
                        state_next = tdpt_pkg::ST_RESULT;
                    end else if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_RESULT;
                    end else begin
                        state_next = tdpt_pkg::ST_DIVHI;
                    end
                end
            end
            tdpt_pkg::ST_DIVHI: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_RESULT;
                    end else begin
                        d_next     = d_reg + W'(tdpt_pkg::WHEEL_STEP);
                        state_next = tdpt_pkg::ST_DIVLO;
                    end
                end
            end
            tdpt_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == tdpt_pkg::ST_IDLE);
        in_div      = 1'b0;
        div_divisor = d_reg;
        case (state_reg)
            tdpt_pkg::ST_DIV3: begin
                in_div      = 1'b1;
                div_divisor = W'(tdpt_pkg::SMALL_DIVISOR);
            end
            tdpt_pkg::ST_DIVLO: begin
                in_div      = 1'b1;
                div_divisor = d_reg;
            end
            tdpt_pkg::ST_DIVHI: begin
                in_div      = 1'b1;
                div_divisor = d_reg + W'(tdpt_pkg::PAIR_OFFSET);
            end
            default: begin
                in_div      = 1'b0;
                div_divisor = d_reg;
            end
        endcase
        div_start = in_div && !div_stat.busy && !div_stat.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tdpt_pkg::ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        prime_reg <= prime_next;
        if (state_reg == tdpt_pkg::ST_RESULT && out_free) begin
            m_flag_reg <= prime_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_prime_flag = m_flag_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == tdpt_pkg::ST_DIV3 ||
                           state_reg == tdpt_pkg::ST_DIVLO ||
                           state_reg == tdpt_pkg::ST_DIVHI))
        else $error("divider finished outside a divide state");

    a_divisor_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdpt_pkg::ST_DIVLO || state_reg == tdpt_pkg::ST_DIVHI)
            |-> d_reg[0])
        else $error("wheel divisor is even");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdpt_pkg::ST_RESULT && out_free)
            |=> (m_valid && state_reg == tdpt_pkg::ST_IDLE))
        else $error("finished item did not reach the output register");

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (in_div && !div_start))
        else $error("divider running without a divide state or restarted");

endmodule

`default_nettype wire

[hw/rtl/tdpt_serial_div.sv]
// Bit-serial restoring divider: one dividend bit per cycle, quotient and remainder.
`default_nettype none

module tdpt_serial_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [VALUE_WIDTH-1:0]     dividend,
    input  wire logic [VALUE_WIDTH-1:0]     divisor,
    output tdpt_pkg::tdpt_div_stat_t        stat,
    output logic      [VALUE_WIDTH-1:0]     quotient,
    output logic      [VALUE_WIDTH-1:0]     remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [VALUE_WIDTH-1:0] dsr_reg;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic [VALUE_WIDTH-1:0] rem_step;

    always_comb begin
        trial    = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_step = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            quot_reg  <= '0;
            dsr_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_step;
            quot_reg  <= {quot_reg[VALUE_WIDTH-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[tb/sv/tb_trial_division_prime_test.sv]
// Testbench for trial_division_prime_test: random and directed candidates, self-checked.
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] s_candidate = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic                                 m_is_prime_flag;

    logic expected_flags[$];
    int   err_count = 0;
    bit   no_idle = 1'b0;
    int   hold_off_request = 0;
    int   hold_left = 0;
    int   stall_left = 0;

    trial_division_prime_test dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_candidate     (s_candidate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_prime_flag (m_is_prime_flag)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic is_prime_6k(logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] cand);
        longint unsigned n;
        longint unsigned d;
        n = cand;
        if (cand[tdpt_pkg::CANDIDATE_WIDTH-1]) return 1'b0;
        if (n <= 1) return 1'b0;
        if (n <= 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        for (d = 5; d <= n / d; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] random_candidate();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'h8000_0000 | $urandom;
        if (r < 20) return $urandom_range(0, 1 << 20);
        if (r < 60) begin
            k = $urandom_range(1, 2500);
            return $urandom_range(0, 1) ? 6 * k + 1 : 6 * k - 1;
        end
        return $urandom_range(0, 16383);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_candidate(input logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_flags.push_back(is_prime_6k(value));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge aclk);
    endtask

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_off_request > 0) begin
            hold_left = hold_off_request - 1;
            hold_off_request = 0;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (no_idle || $urandom_range(0, 99) < 60) begin
            m_ready <= 1'b1;
        end else begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_flags.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                if (m_is_prime_flag !== expected_flags[0])
                    report_mismatch($sformatf("is_prime_flag %b, expected %b",
                                              m_is_prime_flag, expected_flags[0]));
                void'(expected_flags.pop_front());
            end
        end
    end

    task automatic test_trivial_values();
        send_candidate(32'h8000_0000);
        send_candidate(32'hFFFF_FFFF);
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'd2);
        send_candidate(32'd3);
        send_candidate(32'd4);
        send_candidate(32'd6);
        send_candidate(32'd9);
    endtask

    task automatic test_wheel_edges();
        send_candidate(32'd5);
        send_candidate(32'd7);
        send_candidate(32'd11);
        send_candidate(32'd13);
        send_candidate(32'd25);
        send_candidate(32'd35);
        send_candidate(32'd49);
        send_candidate(32'd121);
        send_candidate(32'd143);
        send_candidate(32'd169);
        send_candidate(32'd187);
        send_candidate(32'd289);
        send_candidate(32'd323);
    endtask

    task automatic test_top_of_range();
        send_candidate(32'h7FFF_FFFE);
        send_candidate(32'h7FFF_FFFD);
        send_candidate(32'h7FFF_FFFF);
    endtask

    task automatic test_random_values();
        repeat (40) send_candidate(random_candidate());
    endtask

    task automatic test_output_backpressure();
        hold_off_request = 1000;
        repeat (6) send_candidate($urandom_range(0, 200));
    endtask

    task automatic test_drain_pause();
        repeat (5) send_candidate(random_candidate());
        drain_results();
        repeat (5) send_candidate(random_candidate());
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (20) send_candidate($urandom_range(0, 4095));
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_trivial_values();
        test_wheel_edges();
        test_top_of_range();
        test_back_to_back();
        test_output_backpressure();
        test_drain_pause();
        test_random_values();
        drain_results();
        repeat (50) @(posedge aclk);
        if (err_count == 0)
            $display("tb_trial_division_prime_test: PASS");
        else
            $display("tb_trial_division_prime_test: FAIL");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("tb_trial_division_prime_test: FAIL");
        $finish;
    end

endmodule
